// ===== rtl/core/camera_block_stream_parser_macros.svh =====
// Assertion helpers shared by the parser modules.
// Both expect i_clk and i_rst_n in the enclosing module.
`ifndef CAMERA_BLOCK_STREAM_PARSER_MACROS_SVH
`define CAMERA_BLOCK_STREAM_PARSER_MACROS_SVH

// Condition that must hold at every edge out of reset
`define CBSP_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication
`define CBSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cbsp_pkg.sv =====
package cbsp_pkg;

    // Register map
    localparam int CfgIdxW = 8;
    localparam logic [CfgIdxW-1:0] CFG_IDX_START_WORD   = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_IDX_SWAPPED_WORD = 8'd1;

    // Register reset values
    localparam logic [15:0] START_WORD_RESET   = 16'haa55;
    localparam logic [15:0] SWAPPED_WORD_RESET = 16'h55aa;

    // Previous-word seed at the start of a hunt
    localparam logic [15:0] HUNT_SEED = 16'h00ff;

    // Depth of the word queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Result kinds
    localparam logic KIND_BLOCK     = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // One byte as seen by the back end, paired with the byte before it
    typedef struct packed {
        logic [15:0] word;
        logic        eq_start;
        logic        eq_swapped;
        logic        is_zero;
    } t_word_item;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [15:0] signature;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [15:0] obj_width;
        logic [15:0] obj_height;
    } t_result;

endpackage

// ===== rtl/core/cbsp_front.sv =====
module cbsp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_rx_byte,
    input  logic [15:0]           i_start_word,
    input  logic [15:0]           i_swapped_start_word,
    input  logic                  i_queue_ready,
    output logic                  o_push,
    output cbsp_pkg::t_word_item  o_item
);

    logic [7:0]  r_prev_byte;
    logic [15:0] cand_word;

    // Accept whenever the queue has room
    assign o_in_ready = i_queue_ready;
    assign o_push     = i_in_valid & i_queue_ready;

    // Candidate word: previous byte high, this byte low.
    // The back end only uses it on a low-byte item, whose high byte is
    // always the item just before it.
    assign cand_word = {r_prev_byte, i_rx_byte};

    // Classify against the sync words
    always_comb begin
        o_item.word       = cand_word;
        o_item.eq_start   = (cand_word == i_start_word);
        o_item.eq_swapped = (cand_word == i_swapped_start_word);
        o_item.is_zero    = (cand_word == 16'h0000);
    end

    // Previous byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_byte <= '0;
        end else if (o_push) begin
            r_prev_byte <= i_rx_byte;
        end
    end

endmodule

// ===== rtl/core/cbsp_queue.sv =====
`include "camera_block_stream_parser_macros.svh"

module cbsp_queue #(
    parameter int DEPTH = cbsp_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  cbsp_pkg::t_word_item  i_item,
    output logic                  o_ready,
    output logic                  o_valid,
    output cbsp_pkg::t_word_item  o_item,
    input  logic                  i_pop
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    cbsp_pkg::t_word_item r_slots [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_ready = (r_count != FullCnt);
    assign o_valid = (r_count != '0);
    assign o_item  = r_slots[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Slot storage, payload only
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_item;
        end
    end

    `CBSP_ASSERT_IMP(a_no_push_full, i_push, o_ready, "push into full queue")
    `CBSP_ASSERT_IMP(a_no_pop_empty, i_pop, o_valid, "pop from empty queue")
    `CBSP_ASSERT_NOW(a_count_bound, r_count <= FullCnt, "queue count beyond depth")

endmodule

// ===== rtl/core/cbsp_back.sv =====
`include "camera_block_stream_parser_macros.svh"

module cbsp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  cbsp_pkg::t_word_item  i_item,
    output logic                  o_pop,
    input  logic [15:0]           i_start_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output cbsp_pkg::t_result     o_result
);

    localparam logic [2:0] LastHeldIdx = 3'd4;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_CHECKSUM,
        MODE_DATA,
        MODE_TRAILER
    } t_mode;

    t_mode        r_mode, n_mode;
    logic         r_phase, n_phase;
    logic         r_drop, n_drop;
    logic [15:0]  r_prev_word, n_prev_word;
    logic [2:0]   r_word_index, n_word_index;
    logic [18:0]  r_running_sum, n_running_sum;
    logic [15:0]  r_expected_sum, n_expected_sum;
    logic [15:0]  r_block_words [4];
    logic [15:0]  n_block_words [4];
    logic         r_out_valid, n_out_valid;
    cbsp_pkg::t_result r_result, n_result;

    logic [18:0]  sum_next;
    logic         frame_end;
    logic         block_ok;

    // Take an item when the output register is free or being drained
    assign o_pop       = i_valid & (~r_out_valid | i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign sum_next    = r_running_sum + 19'(i_item.word);

    // Parser next state
    always_comb begin
        n_mode         = r_mode;
        n_phase        = r_phase;
        n_drop         = r_drop;
        n_prev_word    = r_prev_word;
        n_word_index   = r_word_index;
        n_running_sum  = r_running_sum;
        n_expected_sum = r_expected_sum;
        n_block_words  = r_block_words;
        frame_end      = 1'b0;
        block_ok       = 1'b0;

        if (o_pop) begin
            if (r_drop) begin
                n_drop = 1'b0;
            end else if (!r_phase) begin
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                unique case (r_mode)
                    MODE_HUNT: begin
                        if (i_item.is_zero && r_prev_word == 16'h0000) begin
                            n_prev_word = cbsp_pkg::HUNT_SEED;
                        end else if (i_item.eq_start && r_prev_word == i_start_word) begin
                            n_mode      = MODE_CHECKSUM;
                            n_prev_word = cbsp_pkg::HUNT_SEED;
                        end else begin
                            if (i_item.eq_swapped) begin
                                n_drop = 1'b1;
                            end
                            n_prev_word = i_item.word;
                        end
                    end
                    MODE_CHECKSUM: begin
                        if (i_item.eq_start) begin
                            frame_end = 1'b1;
                        end else if (i_item.is_zero) begin
                            frame_end   = 1'b1;
                            n_mode      = MODE_HUNT;
                            n_prev_word = cbsp_pkg::HUNT_SEED;
                        end else begin
                            n_expected_sum = i_item.word;
                            n_running_sum  = '0;
                            n_word_index   = '0;
                            n_mode         = MODE_DATA;
                        end
                    end
                    MODE_DATA: begin
                        n_running_sum = sum_next;
                        if (r_word_index != LastHeldIdx) begin
                            n_block_words[r_word_index[1:0]] = i_item.word;
                            n_word_index = r_word_index + 1'b1;
                        end else begin
                            n_word_index = '0;
                            n_mode       = MODE_TRAILER;
                            block_ok     = (sum_next == {3'b000, r_expected_sum});
                        end
                    end
                    MODE_TRAILER: begin
                        if (i_item.eq_start) begin
                            n_mode = MODE_CHECKSUM;
                        end else begin
                            frame_end   = 1'b1;
                            n_mode      = MODE_HUNT;
                            n_prev_word = cbsp_pkg::HUNT_SEED;
                        end
                    end
                    default: n_mode = MODE_HUNT;
                endcase
            end
        end
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid & ~i_out_ready;
        n_result    = r_result;
        if (frame_end) begin
            n_out_valid         = 1'b1;
            n_result.kind       = cbsp_pkg::KIND_FRAME_END;
            n_result.signature  = '0;
            n_result.x_pos      = '0;
            n_result.y_pos      = '0;
            n_result.obj_width  = '0;
            n_result.obj_height = '0;
        end else if (block_ok) begin
            n_out_valid         = 1'b1;
            n_result.kind       = cbsp_pkg::KIND_BLOCK;
            n_result.signature  = r_block_words[0];
            n_result.x_pos      = r_block_words[1];
            n_result.y_pos      = r_block_words[2];
            n_result.obj_width  = r_block_words[3];
            n_result.obj_height = i_item.word;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_HUNT;
            r_phase      <= 1'b0;
            r_drop       <= 1'b0;
            r_prev_word  <= cbsp_pkg::HUNT_SEED;
            r_word_index <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_phase      <= n_phase;
            r_drop       <= n_drop;
            r_prev_word  <= n_prev_word;
            r_word_index <= n_word_index;
            r_out_valid  <= n_out_valid;
        end
        r_running_sum  <= n_running_sum;
        r_expected_sum <= n_expected_sum;
        r_block_words  <= n_block_words;
        r_result       <= n_result;
    end

    `CBSP_ASSERT_IMP(a_drop_at_boundary, r_drop, !r_phase, "byte drop pending mid-word")
    `CBSP_ASSERT_NOW(a_index_bound, r_word_index <= LastHeldIdx, "word index out of range")
    `CBSP_ASSERT_IMP(a_index_idle, r_mode != MODE_DATA, r_word_index == 3'd0,
        "word index left nonzero outside data mode")

endmodule

// ===== rtl/core/camera_block_stream_parser.sv =====
// Camera block stream parser. Takes one received byte per item on the input
// channel, pairs bytes into big-endian words, hunts for two start words and
// then decodes blocks of checksum, signature, x, y, width and height; a block
// whose 19-bit sum matches its checksum is delivered with kind 0, and a frame
// end (start word or zero in the checksum slot, or no start word after a
// block) is delivered with kind 1 and zeroed fields. A byte item is accepted
// every cycle while the queue has room: the byte front end classifies it
// against the sync words and writes it into a QUEUE_DEPTH-entry queue, and
// the parser back end retires one queued byte per cycle into a single output
// register; the last byte of a result is registered in the queue and then in
// the output register. The back end stalls only while a result waits on the
// output; the queue then absorbs incoming bytes until it is full. The sync
// words are written through the configuration channel (index 0 start word,
// index 1 swapped start word, other indexes ignored), which is always ready.
module camera_block_stream_parser #(
    parameter int QUEUE_DEPTH = cbsp_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Byte input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_rx_byte,
    // Result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_kind,
    output logic [15:0]                   o_signature,
    output logic [15:0]                   o_x_pos,
    output logic [15:0]                   o_y_pos,
    output logic [15:0]                   o_obj_width,
    output logic [15:0]                   o_obj_height,
    // Configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbsp_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);

    logic [15:0] r_start_word;
    logic [15:0] r_swapped_start_word;

    logic                 queue_ready;
    logic                 push;
    cbsp_pkg::t_word_item front_item;
    logic                 queue_valid;
    cbsp_pkg::t_word_item queue_item;
    logic                 pop;
    cbsp_pkg::t_result    result;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_word         <= cbsp_pkg::START_WORD_RESET;
            r_swapped_start_word <= cbsp_pkg::SWAPPED_WORD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cbsp_pkg::CFG_IDX_START_WORD:   r_start_word         <= i_cfg_data;
                cbsp_pkg::CFG_IDX_SWAPPED_WORD: r_swapped_start_word <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cbsp_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_rx_byte            (i_rx_byte),
        .i_start_word         (r_start_word),
        .i_swapped_start_word (r_swapped_start_word),
        .i_queue_ready        (queue_ready),
        .o_push               (push),
        .o_item               (front_item)
    );

    cbsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_item  (queue_item),
        .i_pop   (pop)
    );

    cbsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .i_item       (queue_item),
        .o_pop        (pop),
        .i_start_word (r_start_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (result)
    );

    assign o_kind       = result.kind;
    assign o_signature  = result.signature;
    assign o_x_pos      = result.x_pos;
    assign o_y_pos      = result.y_pos;
    assign o_obj_width  = result.obj_width;
    assign o_obj_height = result.obj_height;

endmodule
